>>> src/windowed_pid_controller_assert.svh
// Assertion macros for the windowed PID controller checker.
// Included by the checker file; no other dependencies.
`ifndef WINDOWED_PID_CONTROLLER_ASSERT_SVH
`define WINDOWED_PID_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define WPID_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WPID_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define WPID_ASSERT_ALW_NXT(label, ck, ante, cons, msg) \
  label: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/wpid_pkg.sv
// Shared types, widths, register indexes and helpers for the windowed PID controller.
// Used by every module of the block; depends on nothing.
package wpid_pkg;

  // Field widths.
  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int ERR_W     = 17;
  localparam int LIM_W     = 17;
  localparam int OPT_W     = 4;
  localparam int DRIVE_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  // Gains are Q8.8.
  localparam int Q_SHIFT = 8;

  // Default sizes.
  localparam int DEF_WINDOW_DEPTH = 16;
  localparam int DEF_DERIV_SPAN   = 4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NEG_LIMIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_LIM  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OPTIONS    = 3'd7;

  // Bit positions in the options register.
  localparam int OPT_POS_LIM    = 0;
  localparam int OPT_NEG_LIM    = 1;
  localparam int OPT_DERIV_LIM  = 2;
  localparam int OPT_AUTO_CLEAR = 3;

  // Sign of the most recent nonzero error.
  typedef enum logic [1:0] {
    SIGN_NONE,
    SIGN_POS,
    SIGN_NEG
  } sign_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [GAIN_W-1:0] gain_prop;
    logic [GAIN_W-1:0] gain_integ;
    logic [GAIN_W-1:0] gain_deriv;
    logic [GAIN_W-1:0] setpoint;
    logic [LIM_W-1:0]  integ_pos_limit;
    logic [LIM_W-1:0]  integ_neg_limit;
    logic [LIM_W-1:0]  deriv_limit;
    logic [OPT_W-1:0]  options;
  } cfg_t;

  // Magnitude of a two's complement error; the error range keeps it within ERR_W bits.
  function automatic logic [ERR_W-1:0] abs_err(input logic [ERR_W-1:0] e);
    return e[ERR_W-1] ? (~e + 1'b1) : e;
  endfunction

endpackage

>>> src/wpid_window.sv
// Integral window: error ring in a registered-read RAM, per-entry valid bits and running sum.
// Depends on wpid_pkg.
module wpid_window import wpid_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int SUM_W        = ERR_W + $clog2(DEF_WINDOW_DEPTH) + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             acc,
  input  logic [ERR_W-1:0] err,
  input  logic             adv,
  output logic [SUM_W-1:0] sum_next
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(WINDOW_DEPTH - 1);

  // Window storage and control state.
  logic [ERR_W-1:0]        mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] ent_valid;
  logic [ERR_W-1:0]        rdata;
  logic [AW-1:0]           ptr;
  logic [SUM_W-1:0]        sum;
  sign_t                   last_sign;

  // Stage one copy of the item whose entry is being read.
  logic [ERR_W-1:0] s1_err;
  logic             s1_clr;
  logic             s1_wr;
  logic [AW-1:0]    s1_addr;
  logic             s1_hit;
  logic             s1_fwd;
  logic [ERR_W-1:0] s1_fwd_data;

  sign_t            new_sign;
  logic             clr;
  logic [AW-1:0]    addr;
  logic             fwd;
  logic [ERR_W-1:0] s1_mag;
  logic             cut;
  logic [ERR_W-1:0] stored;
  logic [ERR_W-1:0] old;
  logic [SUM_W-1:0] sum_base;

  // Sign tracking and clear decision on the incoming error.
  always_comb begin
    new_sign = last_sign;
    if (err != '0) begin
      new_sign = err[ERR_W-1] ? SIGN_NEG : SIGN_POS;
    end
    clr  = (new_sign != last_sign) && cfg.options[OPT_AUTO_CLEAR];
    addr = clr ? '0 : ptr;
    // The stage one item writes the same entry at this edge.
    fwd  = adv && s1_wr && (s1_addr == addr) && !clr;
  end

  // Value that the stage one item stores, after the integral limits.
  always_comb begin
    s1_mag = abs_err(s1_err);
    cut = (!s1_err[ERR_W-1] && cfg.options[OPT_POS_LIM] && (s1_mag >= cfg.integ_pos_limit)) ||
          (s1_err[ERR_W-1] && cfg.options[OPT_NEG_LIM] && (s1_mag >= cfg.integ_neg_limit));
    stored = cut ? '0 : s1_err;
    old = s1_fwd ? s1_fwd_data : (s1_hit ? rdata : '0);
    sum_base = s1_clr ? '0 : sum;
    if (s1_wr) begin
      sum_next = sum_base + {{(SUM_W-ERR_W){stored[ERR_W-1]}}, stored}
                          - {{(SUM_W-ERR_W){old[ERR_W-1]}}, old};
    end else begin
      sum_next = sum_base;
    end
  end

  // Window RAM: read on transfer, write back when stage one moves on.
  always_ff @(posedge clk) begin
    if (acc) begin
      rdata <= mem[addr];
    end
    if (adv && s1_wr) begin
      mem[s1_addr] <= stored;
    end
  end

  // Stage one capture.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_err      <= err;
      s1_clr      <= clr;
      s1_wr       <= (err != '0);
      s1_addr     <= addr;
      s1_hit      <= ent_valid[addr] && !clr;
      s1_fwd      <= fwd;
      s1_fwd_data <= stored;
    end
  end

  // Control state; a clear drops all valid bits at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      sum       <= '0;
      last_sign <= SIGN_NONE;
      ent_valid <= '0;
    end else begin
      if (acc) begin
        last_sign <= new_sign;
        ptr       <= (addr == LAST) ? '0 : addr + 1'b1;
      end
      if (acc && clr) begin
        ent_valid <= '0;
      end else if (adv && s1_wr) begin
        ent_valid[s1_addr] <= 1'b1;
      end
      if (adv) begin
        sum <= sum_next;
      end
    end
  end

endmodule

>>> src/wpid_hist.sv
// Derivative history: ring of past errors in a registered-read RAM with its pointer and count.
// Depends on wpid_pkg.
module wpid_hist import wpid_pkg::*; #(
  parameter int DERIV_SPAN = DEF_DERIV_SPAN
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             acc,
  input  logic [ERR_W-1:0] err,
  output logic [ERR_W-1:0] past,
  output logic             den
);

  localparam int PAW = (DERIV_SPAN > 1) ? $clog2(DERIV_SPAN) : 1;
  localparam int CW  = $clog2(DERIV_SPAN + 1);
  localparam logic [PAW-1:0] LAST = PAW'(DERIV_SPAN - 1);
  localparam logic [CW-1:0]  FULL = CW'(DERIV_SPAN);

  logic [ERR_W-1:0] mem [DERIV_SPAN];
  logic [ERR_W-1:0] rdata;
  logic [PAW-1:0]   pptr;
  logic [CW-1:0]    cnt;
  logic             have_prior;
  logic [ERR_W-1:0] prior_error;

  logic             s1_fwd;
  logic [ERR_W-1:0] s1_fwd_data;
  logic             s1_den;

  logic [PAW-1:0] pptr_new;
  logic [CW-1:0]  cnt_new;
  logic [PAW-1:0] ridx;
  logic           fwd;

  // Push of the previous error, then the read index from the updated state.
  always_comb begin
    pptr_new = pptr;
    cnt_new  = cnt;
    if (have_prior) begin
      pptr_new = (pptr == LAST) ? '0 : pptr + 1'b1;
      cnt_new  = (cnt == FULL) ? cnt : cnt + 1'b1;
    end
    ridx = (cnt_new == FULL) ? pptr_new : '0;
    // Reading the entry pushed at this same edge.
    fwd  = have_prior && (ridx == pptr);
  end

  // History RAM: write and read at the transfer edge.
  always_ff @(posedge clk) begin
    if (acc) begin
      if (have_prior) begin
        mem[pptr] <= prior_error;
      end
      rdata       <= mem[ridx];
      s1_fwd      <= fwd;
      s1_fwd_data <= prior_error;
      s1_den      <= (cnt_new != '0);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pptr        <= '0;
      cnt         <= '0;
      have_prior  <= 1'b0;
      prior_error <= '0;
    end else if (acc) begin
      pptr        <= pptr_new;
      cnt         <= cnt_new;
      have_prior  <= 1'b1;
      prior_error <= err;
    end
  end

  assign past = s1_fwd ? s1_fwd_data : rdata;
  assign den  = s1_den;

endmodule

>>> src/wpid_arith.sv
// Output arithmetic: three gain products, Q8.8 scaling toward zero, sum and saturation.
// Depends on wpid_pkg.
module wpid_arith import wpid_pkg::*; #(
  parameter int SUM_W = ERR_W + $clog2(DEF_WINDOW_DEPTH) + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ERR_W-1:0]   in_err,
  input  logic [SUM_W-1:0]   in_sum,
  input  logic [ERR_W:0]     in_deriv,
  input  logic               in_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DRIVE_W-1:0] out_drive
);

  localparam int PW  = GAIN_W + ERR_W;
  localparam int IW  = GAIN_W + SUM_W;
  localparam int DW  = GAIN_W + ERR_W + 1;
  localparam int TW0 = ((IW > DW) ? IW : DW) - Q_SHIFT + 2;
  localparam int TW  = (TW0 > DRIVE_W + 1) ? TW0 : DRIVE_W + 1;
  localparam int Q_ROUND = (1 << Q_SHIFT) - 1;
  localparam logic signed [TW-1:0] DMAX = TW'({1'b0, {(DRIVE_W-1){1'b1}}});
  localparam logic signed [TW-1:0] DMIN = ~DMAX;

  logic a_valid, b_valid, c_valid;
  logic ready_a, ready_b, ready_c;

  logic signed [PW-1:0] a_p;
  logic signed [IW-1:0] a_i;
  logic signed [DW-1:0] a_d;

  logic [PW-Q_SHIFT-1:0] b_p;
  logic [IW-Q_SHIFT-1:0] b_i;
  logic [DW-Q_SHIFT-1:0] b_d;

  logic [DRIVE_W-1:0] drive;

  logic [ERR_W:0]       d_op;
  logic signed [PW-1:0] p_bias;
  logic signed [IW-1:0] i_bias;
  logic signed [DW-1:0] d_bias;
  logic signed [TW-1:0] total;
  logic [DRIVE_W-1:0]   drive_next;

  // Each stage moves when the one after it is empty or moving.
  assign ready_c  = !c_valid || out_ready;
  assign ready_b  = !b_valid || ready_c;
  assign ready_a  = !a_valid || ready_b;
  assign in_ready = ready_a;

  assign d_op = in_den ? in_deriv : '0;

  // Bias negative products so the shift truncates toward zero.
  always_comb begin
    p_bias = a_p + (a_p[PW-1] ? PW'(Q_ROUND) : PW'(0));
    i_bias = a_i + (a_i[IW-1] ? IW'(Q_ROUND) : IW'(0));
    d_bias = a_d + (a_d[DW-1] ? DW'(Q_ROUND) : DW'(0));
  end

  // Sum of the three terms and saturation to the drive width.
  always_comb begin
    total = TW'($signed(b_p)) + TW'($signed(b_i)) + TW'($signed(b_d));
    if (total > DMAX) begin
      drive_next = DMAX[DRIVE_W-1:0];
    end else if (total < DMIN) begin
      drive_next = DMIN[DRIVE_W-1:0];
    end else begin
      drive_next = total[DRIVE_W-1:0];
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (ready_a) begin
        a_valid <= in_valid;
      end
      if (ready_b) begin
        b_valid <= a_valid;
      end
      if (ready_c) begin
        c_valid <= b_valid;
      end
    end
  end

  // Stage payloads: products, scaled terms, saturated drive.
  always_ff @(posedge clk) begin
    if (in_valid && ready_a) begin
      a_p <= $signed(cfg.gain_prop) * $signed(in_err);
      a_i <= $signed(cfg.gain_integ) * $signed(in_sum);
      a_d <= $signed(cfg.gain_deriv) * $signed(d_op);
    end
    if (a_valid && ready_b) begin
      b_p <= p_bias[PW-1:Q_SHIFT];
      b_i <= i_bias[IW-1:Q_SHIFT];
      b_d <= d_bias[DW-1:Q_SHIFT];
    end
    if (b_valid && ready_c) begin
      drive <= drive_next;
    end
  end

  assign out_valid = c_valid;
  assign out_drive = drive;

endmodule

>>> src/windowed_pid_controller.sv
// Windowed PID controller: one drive value for each measured sample.
// Depends on wpid_pkg, wpid_window, wpid_hist and wpid_arith.
//
// The block takes one sample per clock while the output side is not stalled and returns
// one drive per sample, in order, through stage one and the product, scaling and drive
// registers of the arithmetic. The rate is set by the integral window RAM: each item
// reads its entry at the transfer edge and writes it back when it leaves stage one, with
// a bypass when the next item hits the same entry. A sign change with auto clear empties
// the window at once through per-entry valid bits, so there is no clearing pass after
// reset or on a clear. Configuration writes are taken in the cycle they are offered and
// must be made while the block holds no items.
module windowed_pid_controller import wpid_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  parameter int DERIV_SPAN   = DEF_DERIV_SPAN
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream. tdata: sample [15:0].
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,
  // Output stream. tdata: drive [31:0].
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DRIVE_W-1:0]    m_axis_tdata,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = ERR_W + $clog2(WINDOW_DEPTH) + 1;

  cfg_t cfg;

  logic             acc;
  logic [ERR_W-1:0] err;
  logic             s1_valid;
  logic             s1_ready;
  logic             s1_adv;
  logic [ERR_W-1:0] s1_err;
  logic [SUM_W-1:0] win_sum;
  logic [ERR_W-1:0] past_err;
  logic             past_den;
  logic [ERR_W:0]   deriv;
  logic             d_on;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GAIN_PROP:  cfg.gain_prop       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEG: cfg.gain_integ      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIV: cfg.gain_deriv      <= cfg_data[GAIN_W-1:0];
        REG_SETPOINT:   cfg.setpoint        <= cfg_data[GAIN_W-1:0];
        REG_POS_LIMIT:  cfg.integ_pos_limit <= cfg_data[LIM_W-1:0];
        REG_NEG_LIMIT:  cfg.integ_neg_limit <= cfg_data[LIM_W-1:0];
        REG_DERIV_LIM:  cfg.deriv_limit     <= cfg_data[LIM_W-1:0];
        REG_OPTIONS:    cfg.options         <= cfg_data[OPT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input transfer and error.
  assign s_axis_tready = !s1_valid || s1_ready;
  assign acc    = s_axis_tvalid && s_axis_tready;
  assign s1_adv = s1_valid && s1_ready;
  assign err    = {cfg.setpoint[GAIN_W-1], cfg.setpoint}
                - {s_axis_tdata[SAMPLE_W-1], s_axis_tdata};

  // Stage one holds the item while its RAM reads come back.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_err <= err;
    end
  end

  wpid_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SUM_W        (SUM_W)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .acc      (acc),
    .err      (err),
    .adv      (s1_adv),
    .sum_next (win_sum)
  );

  wpid_hist #(
    .DERIV_SPAN (DERIV_SPAN)
  ) u_hist (
    .clk  (clk),
    .rst  (rst),
    .acc  (acc),
    .err  (err),
    .past (past_err),
    .den  (past_den)
  );

  // Derivative and its limit on the error magnitude.
  assign deriv = {s1_err[ERR_W-1], s1_err} - {past_err[ERR_W-1], past_err};
  assign d_on  = past_den &&
                 !(cfg.options[OPT_DERIV_LIM] && (abs_err(s1_err) > cfg.deriv_limit));

  wpid_arith #(
    .SUM_W (SUM_W)
  ) u_arith (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_err    (s1_err),
    .in_sum    (win_sum),
    .in_deriv  (deriv),
    .in_den    (d_on),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_drive (m_axis_tdata)
  );

endmodule

>>> src/wpid_checker.sv
// Port-level checker for the windowed PID controller, bound to the top level.
// Depends on wpid_pkg and windowed_pid_controller_assert.svh.
`include "windowed_pid_controller_assert.svh"

module wpid_checker import wpid_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [DRIVE_W-1:0]    m_axis_tdata,
  input logic                  cfg_valid,
  input logic                  cfg_ready
);

  // A stalled result keeps its value until the transfer.
  `WPID_ASSERT_NXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "drive changed while stalled")

  // Reset empties the pipeline.
  `WPID_ASSERT_ALW_NXT(a_rst_empty, clk, rst, !m_axis_tvalid, "result present after reset")

  // A sink that takes results never throttles the input.
  `WPID_ASSERT_IMP(a_no_block, clk, rst, m_axis_tready, s_axis_tready, "input blocked while output drains")

  // Configuration writes are taken in the cycle they are offered.
  `WPID_ASSERT_IMP(a_cfg_take, clk, rst, cfg_valid, cfg_ready, "configuration write not taken")

endmodule

bind windowed_pid_controller wpid_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);
